// ===== rtl/assert_macros.svh =====
// assertion macros used by chs_lba_translator
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

// implication checked in the cycle after the condition
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");

`endif

// ===== rtl/chs_pkg.sv =====
// types and status codes for the chs/lba translator
// no dependencies
package chs_pkg;

  localparam int STATUS_BITS = 3;

  localparam logic [STATUS_BITS-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_HEADS0     = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_SPT0       = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_SEC0       = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_HEAD_RANGE = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_SEC_RANGE  = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_OVERFLOW   = 3'd6;

  localparam logic CMD_TO_LBA = 1'b0;
  localparam logic CMD_TO_CHS = 1'b1;

  localparam int CFG_HEADS = 0;
  localparam int CFG_SPT   = 1;

  localparam int FIELD_BITS = 48;
  localparam int BYTE_BITS  = 8;

  // control that travels with each pipeline slot
  typedef struct packed {
    logic                   valid;
    logic                   cmd;
    logic [STATUS_BITS-1:0] status;
  } ctl_t;

endpackage

// ===== rtl/chs_cell.sv =====
// one restoring-division cell: one quotient bit per cell, one cell per stage
// depends on chs_pkg
module chs_cell #(
  parameter int W = 48,
  parameter int D = 16,
  parameter int P = 8,
  parameter int BIT = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  chs_pkg::ctl_t       ctl_in,
  input  logic [W-1:0]        rem_in,
  input  logic [W-1:0]        quo_in,
  input  logic [D-1:0]        div_in,
  input  logic [P-1:0]        pass_in,
  output chs_pkg::ctl_t       ctl_out,
  output logic [W-1:0]        rem_out,
  output logic [W-1:0]        quo_out,
  output logic [D-1:0]        div_out,
  output logic [P-1:0]        pass_out
);

  logic [W+D-1:0] shifted;
  logic           fits;
  logic [W-1:0]   rem_next;

  always_comb begin
    shifted  = (W+D)'(div_in) << BIT;
    fits     = ({{D{1'b0}}, rem_in} >= shifted);
    rem_next = fits ? rem_in - shifted[W-1:0] : rem_in;
  end

  always_ff @(posedge clk) begin
    if (rst) ctl_out.valid <= 1'b0;
    else if (en) ctl_out.valid <= ctl_in.valid;
    if (en) begin
      ctl_out.cmd    <= ctl_in.cmd;
      ctl_out.status <= ctl_in.status;
      rem_out  <= rem_next;
      quo_out  <= quo_in | (W'(fits) << BIT);
      div_out  <= div_in;
      pass_out <= pass_in;
    end
  end

endmodule

// ===== rtl/chs_divider.sv =====
// chain of division cells giving quotient and remainder, one stage per bit
// depends on chs_pkg, chs_cell
module chs_divider #(
  parameter int W = 48,
  parameter int D = 16,
  parameter int P = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  chs_pkg::ctl_t ctl_in,
  input  logic [W-1:0]  num_in,
  input  logic [D-1:0]  div_in,
  input  logic [P-1:0]  pass_in,
  output chs_pkg::ctl_t ctl_out,
  output logic [W-1:0]  quo_out,
  output logic [W-1:0]  rem_out,
  output logic [D-1:0]  div_out,
  output logic [P-1:0]  pass_out
);

  chs_pkg::ctl_t ctl_c  [W+1];
  logic [W-1:0]  rem_c  [W+1];
  logic [W-1:0]  quo_c  [W+1];
  logic [D-1:0]  div_c  [W+1];
  logic [P-1:0]  pass_c [W+1];

  assign ctl_c[0]  = ctl_in;
  assign rem_c[0]  = num_in;
  assign quo_c[0]  = '0;
  assign div_c[0]  = div_in;
  assign pass_c[0] = pass_in;

  for (genvar i = 0; i < W; i++) begin : g_cell
    chs_cell #(.W(W), .D(D), .P(P), .BIT(W-1-i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctl_in(ctl_c[i]), .rem_in(rem_c[i]), .quo_in(quo_c[i]),
      .div_in(div_c[i]), .pass_in(pass_c[i]),
      .ctl_out(ctl_c[i+1]), .rem_out(rem_c[i+1]), .quo_out(quo_c[i+1]),
      .div_out(div_c[i+1]), .pass_out(pass_c[i+1])
    );
  end

  assign ctl_out  = ctl_c[W];
  assign quo_out  = quo_c[W];
  assign rem_out  = rem_c[W];
  assign div_out  = div_c[W];
  assign pass_out = pass_c[W];

endmodule

// ===== rtl/chs_lba_translator.sv =====
// chs/lba address translator: multiply path and a chain of divider cells
// depends on chs_pkg, chs_divider, assert_macros.svh
//
// usage:
//   input channel in_valid/in_ready carries cmd, cylinder, head, sector,
//   lba_in; output channel out_valid/out_ready carries status, lba_out,
//   cyl_out, head_out, sector_out. one result per transaction, in order.
//   cmd 0 gives lba = (heads*spt)*c + spt*h + s-1, cmd 1 gives c/h/s.
//   geometry registers: index 0 head_count, index 1 sectors_per_track, written
//   through cfg_we/cfg_index/cfg_data; the user must write them only while idle,
//   the block does not enforce this. pipeline: input and product registers,
//   two chained dividers of one stage per quotient bit, final output register.
//   throughput: one transaction per cycle unless a stalled receiver holds it.
//   the whole pipeline advances only when its last slot is empty or taken,
//   so a stalled receiver holds every stage; in_ready falls with it.
//   reset clears all slot valid bits and restores 16 heads, 63 sectors.
`include "assert_macros.svh"
module chs_lba_translator #(
  parameter int LBA_BITS  = 48,
  parameter int GEOM_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [47:0] cylinder,
  input  logic [7:0]  head,
  input  logic [7:0]  sector,
  input  logic [47:0] lba_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [47:0] lba_out,
  output logic [47:0] cyl_out,
  output logic [7:0]  head_out,
  output logic [7:0]  sector_out
);

  localparam int G  = GEOM_BITS;
  localparam int G2 = 2 * GEOM_BITS;
  localparam int W  = LBA_BITS;
  localparam int P  = G2;

  logic [G-1:0] heads;
  logic [G-1:0] spt;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      heads <= G'(16);
      spt   <= G'(63);
    end else if (cfg_we) begin
      if (cfg_index == 1'(chs_pkg::CFG_HEADS)) heads <= G'(cfg_data);
      else spt <= G'(cfg_data);
    end
  end

  // stage 0: checks and small products
  chs_pkg::ctl_t       c0;
  logic [47:0]         cyl0;
  logic [G2-1:0]       hs0;
  logic [G2:0]         tail0;
  logic [47:0]         lba0;
  logic [G-1:0]        heads0;
  logic [G-1:0]        spt0;
  logic [2:0]          st_in;

  always_comb begin
    st_in = chs_pkg::ST_OK;
    if (heads == '0) st_in = chs_pkg::ST_HEADS0;
    else if (spt == '0) st_in = chs_pkg::ST_SPT0;
    else if (cmd == chs_pkg::CMD_TO_LBA) begin
      if (sector == '0) st_in = chs_pkg::ST_SEC0;
      else if ({{G{1'b0}}, head} >= {8'd0, heads}) st_in = chs_pkg::ST_HEAD_RANGE;
      else if ({{G{1'b0}}, sector} > {8'd0, spt}) st_in = chs_pkg::ST_SEC_RANGE;
    end else if (W < 48 && (lba_in >> W) != '0) begin
      st_in = chs_pkg::ST_OVERFLOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) c0.valid <= 1'b0;
    else if (en) c0.valid <= in_valid;
    if (en) begin
      c0.cmd    <= cmd;
      c0.status <= st_in;
      cyl0      <= cylinder;
      hs0       <= G2'(heads) * G2'(spt);
      tail0     <= (G2+1)'(G2'(spt) * G2'(head)) + (G2+1)'(sector) - (G2+1)'(1);
      lba0      <= lba_in;
      heads0    <= heads;
      spt0      <= spt;
    end
  end

  // stage 1: wide product for chs to lba
  localparam int PW = 48 + G2 + 1;
  chs_pkg::ctl_t c1;
  logic [PW-1:0] prod1;
  logic [47:0]   lba1;
  logic [G2-1:0] hs1;
  logic [G-1:0]  heads1;
  logic [G-1:0]  spt1;

  always_ff @(posedge clk) begin
    if (rst) c1.valid <= 1'b0;
    else if (en) c1.valid <= c0.valid;
    if (en) begin
      c1.cmd    <= c0.cmd;
      c1.status <= c0.status;
      prod1     <= PW'(cyl0) * PW'(hs0) + PW'(tail0);
      lba1      <= lba0;
      hs1       <= hs0;
      heads1    <= heads0;
      spt1      <= spt0;
    end
  end

  // divider inputs: first L / spt, quotient then / heads
  logic [W-1:0] num1;
  chs_pkg::ctl_t cd1;
  assign num1 = W'(lba1);
  always_comb begin
    cd1 = c1;
    if (c1.cmd == chs_pkg::CMD_TO_LBA && c1.status == chs_pkg::ST_OK &&
        (prod1 >> W) != '0)
      cd1.status = chs_pkg::ST_OVERFLOW;
  end

  // chs to lba result rides along in the pass-through lanes of both dividers
  chs_pkg::ctl_t ca;
  logic [W-1:0]  qa;
  logic [W-1:0]  ra;
  logic [G-1:0]  spta;
  logic [P+W-1:0] passa;
  logic [P+W-1:0] passb;
  chs_pkg::ctl_t cb;
  logic [W-1:0]  qb;
  logic [W-1:0]  rb;
  logic [G-1:0]  headsb;

  chs_divider #(.W(W), .D(G), .P(P+W)) u_div_spt (
    .clk(clk), .rst(rst), .en(en), .ctl_in(cd1), .num_in(num1), .div_in(spt1),
    .pass_in({G2'(heads1), W'(prod1)}),
    .ctl_out(ca), .quo_out(qa), .rem_out(ra), .div_out(spta), .pass_out(passa)
  );

  chs_divider #(.W(W), .D(G), .P(P+W)) u_div_heads (
    .clk(clk), .rst(rst), .en(en), .ctl_in(ca), .num_in(qa),
    .div_in(passa[P+W-1 -: G2] == '0 ? G'(1) : G'(passa[P+W-1 -: G2])),
    .pass_in({G2'(ra), passa[W-1:0]}),
    .ctl_out(cb), .quo_out(qb), .rem_out(rb), .div_out(headsb), .pass_out(passb)
  );

  logic ok_lba;
  logic ok_chs;
  assign ok_lba = cb.status == chs_pkg::ST_OK && cb.cmd == chs_pkg::CMD_TO_LBA;
  assign ok_chs = cb.status == chs_pkg::ST_OK && cb.cmd == chs_pkg::CMD_TO_CHS;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= cb.valid;
    if (en) begin
      status     <= cb.status;
      lba_out    <= ok_lba ? 48'(passb[W-1:0]) : '0;
      cyl_out    <= ok_chs ? 48'(qb) : '0;
      head_out   <= ok_chs ? 8'(rb) : '0;
      sector_out <= ok_chs ? 8'(passb[P+W-1 -: G2] + G2'(1)) : '0;
    end
  end

  logic unused;
  assign unused = ^{spta, headsb};

  `ASSERT_IMPL(a_stall_hold, clk, rst, out_valid && !out_ready, !in_ready)
  `ASSERT_NEXT(a_out_keep, clk, rst, out_valid && !out_ready, out_valid && $stable(status))
  `ASSERT_IMPL(a_err_zero, clk, rst, out_valid && status != chs_pkg::ST_OK,
    lba_out == '0 && cyl_out == '0 && head_out == '0 && sector_out == '0)

endmodule
